// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, switched off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/tpp_pkg.sv
`default_nettype none

package tpp_pkg;

    localparam int MAX_PACKET_BYTES = 516;
    localparam int CNT_W            = $clog2(MAX_PACKET_BYTES + 1);
    localparam int PLEN_W           = 10;

    localparam logic [15:0] OPC_RRQ   = 16'd1;
    localparam logic [15:0] OPC_WRQ   = 16'd2;
    localparam logic [15:0] OPC_DATA  = 16'd3;
    localparam logic [15:0] OPC_ACK   = 16'd4;
    localparam logic [15:0] OPC_ERROR = 16'd5;

    localparam logic [2:0] ROLE_OPCODE   = 3'd0;
    localparam logic [2:0] ROLE_NUMBER   = 3'd1;
    localparam logic [2:0] ROLE_FILENAME = 3'd2;
    localparam logic [2:0] ROLE_MODE     = 3'd3;
    localparam logic [2:0] ROLE_PAYLOAD  = 3'd4;
    localparam logic [2:0] ROLE_MESSAGE  = 3'd5;
    localparam logic [2:0] ROLE_TERM     = 3'd6;
    localparam logic [2:0] ROLE_IGNORED  = 3'd7;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_TOO_SHORT   = 2'd1;
    localparam logic [1:0] STATUS_UNTERM      = 2'd2;
    localparam logic [1:0] STATUS_UNKNOWN_OP  = 2'd3;

    typedef enum logic [3:0] {
        PH_OPCODE   = 4'd0,
        PH_NUMBER   = 4'd1,
        PH_FILENAME = 4'd2,
        PH_MODE     = 4'd3,
        PH_MESSAGE  = 4'd4,
        PH_PAYLOAD  = 4'd5,
        PH_TRAILER  = 4'd6,
        PH_UNKNOWN  = 4'd7
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        role;
        logic [7:0]        byte_out;
        logic              done_res;
        logic [1:0]        status;
        logic [15:0]       packet_opcode;
        logic [15:0]       packet_number;
        logic [PLEN_W-1:0] payload_length;
    } t_out_item;

endpackage

`default_nettype wire

// File: hw/rtl/tftp_packet_parser.sv
// The result of an accepted request appears on the output register in the next cycle.
// Throughput: one byte per cycle; a new request is taken while the result register
// is empty or being emptied in the same cycle.
// Reset: synchronous, active low; clears the parse state and the output valid.
// The parse state also returns to its reset value after each byte flagged last.
`default_nettype none

module tftp_packet_parser
    import tpp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);

    t_phase            r_phase, n_phase;
    logic              r_half, n_half;
    logic [15:0]       r_opcode, n_opcode;
    logic [15:0]       r_number, n_number;
    logic [PLEN_W-1:0] r_payload, n_payload;
    logic [1:0]        r_fault, n_fault;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_out_valid;
    t_out_item         r_out, n_out;
    logic              in_accept;
    logic              in_range;
    logic [7:0]        b;

    assign b          = i_in_item.data_byte;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;
    assign in_range   = r_count < CNT_W'(MAX_PACKET_BYTES);

    // Next parse state.
    always_comb begin
        n_phase   = r_phase;
        n_half    = r_half;
        n_opcode  = r_opcode;
        n_number  = r_number;
        n_payload = r_payload;
        n_fault   = r_fault;
        n_count   = r_count;
        if (in_range) begin
            n_count = r_count + CNT_W'(1);
            case (r_phase)
                PH_OPCODE: begin
                    n_opcode = {r_opcode[7:0], b};
                    n_half   = !r_half;
                    if (r_half) begin
                        if (n_opcode == OPC_RRQ || n_opcode == OPC_WRQ) begin
                            n_phase = PH_FILENAME;
                        end else if (n_opcode >= OPC_DATA &&
                                     n_opcode <= OPC_ERROR) begin
                            n_phase = PH_NUMBER;
                        end else begin
                            n_phase = PH_UNKNOWN;
                            n_fault = STATUS_UNKNOWN_OP;
                        end
                    end
                end
                PH_NUMBER: begin
                    n_number = {r_number[7:0], b};
                    n_half   = !r_half;
                    if (r_half) begin
                        if (r_opcode == OPC_DATA) begin
                            n_phase = PH_PAYLOAD;
                        end else if (r_opcode == OPC_ERROR) begin
                            n_phase = PH_MESSAGE;
                        end else begin
                            n_phase = PH_TRAILER;
                        end
                    end
                end
                PH_FILENAME: begin
                    if (b == 8'd0) begin
                        n_phase = PH_MODE;
                    end
                end
                PH_MODE, PH_MESSAGE: begin
                    if (b == 8'd0) begin
                        n_phase = PH_TRAILER;
                    end
                end
                PH_PAYLOAD: begin
                    if (r_payload != {PLEN_W{1'b1}}) begin
                        n_payload = r_payload + PLEN_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result for the current byte; the summary is taken from the updated state.
    always_comb begin
        n_out                = '0;
        n_out.role           = ROLE_IGNORED;
        n_out.byte_out       = b;
        n_out.done_res       = i_in_item.last_byte;
        if (in_range) begin
            case (r_phase)
                PH_OPCODE:   n_out.role = ROLE_OPCODE;
                PH_NUMBER:   n_out.role = ROLE_NUMBER;
                PH_FILENAME: n_out.role = (b == 8'd0) ? ROLE_TERM : ROLE_FILENAME;
                PH_MODE:     n_out.role = (b == 8'd0) ? ROLE_TERM : ROLE_MODE;
                PH_MESSAGE:  n_out.role = (b == 8'd0) ? ROLE_TERM : ROLE_MESSAGE;
                PH_PAYLOAD:  n_out.role = ROLE_PAYLOAD;
                default:     n_out.role = ROLE_IGNORED;
            endcase
        end
        if (i_in_item.last_byte) begin
            if (n_fault != STATUS_OK) begin
                n_out.status        = n_fault;
                n_out.packet_opcode = n_opcode;
            end else if (n_phase == PH_OPCODE || n_phase == PH_NUMBER) begin
                n_out.status = STATUS_TOO_SHORT;
            end else if (n_phase == PH_FILENAME || n_phase == PH_MODE ||
                         n_phase == PH_MESSAGE) begin
                n_out.status        = STATUS_UNTERM;
                n_out.packet_opcode = n_opcode;
                n_out.packet_number = n_number;
            end else begin
                n_out.status        = STATUS_OK;
                n_out.packet_opcode = n_opcode;
                n_out.packet_number = n_number;
                if (n_opcode == OPC_DATA) begin
                    n_out.payload_length = n_payload;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_OPCODE;
            r_half      <= 1'b0;
            r_opcode    <= '0;
            r_number    <= '0;
            r_payload   <= '0;
            r_fault     <= STATUS_OK;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_out_valid <= 1'b1;
                if (i_in_item.last_byte) begin
                    r_phase   <= PH_OPCODE;
                    r_half    <= 1'b0;
                    r_opcode  <= '0;
                    r_number  <= '0;
                    r_payload <= '0;
                    r_fault   <= STATUS_OK;
                    r_count   <= '0;
                end else begin
                    r_phase   <= n_phase;
                    r_half    <= n_half;
                    r_opcode  <= n_opcode;
                    r_number  <= n_number;
                    r_payload <= n_payload;
                    r_fault   <= n_fault;
                    r_count   <= n_count;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

// File: hw/rtl/tpp_checker.sv
`default_nettype none
`include "assert_macros.svh"

module tpp_checker
    import tpp_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire t_in_item  i_in_item,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_item
);

    // The summary only carries values on the last byte of a datagram.
    `ASSERT_IMPL(a_summary_idle, i_clk, i_rst_n, o_out_valid && !o_out_item.done_res, o_out_item.status == STATUS_OK && o_out_item.packet_opcode == 16'd0 && o_out_item.packet_number == 16'd0 && o_out_item.payload_length == '0)

    // A datagram cut short inside a fixed field reports nothing else.
    `ASSERT_IMPL(a_short_empty, i_clk, i_rst_n, o_out_valid && o_out_item.status == STATUS_TOO_SHORT, o_out_item.packet_opcode == 16'd0 && o_out_item.packet_number == 16'd0 && o_out_item.payload_length == '0)

    // Only a well-formed data packet can report a payload length.
    `ASSERT_IMPL(a_plen_data, i_clk, i_rst_n, o_out_valid && o_out_item.payload_length != '0, o_out_item.status == STATUS_OK && o_out_item.packet_opcode == OPC_DATA)

    // A stalled result stays put.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item))

endmodule

bind tftp_packet_parser tpp_checker u_tpp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

`default_nettype wire

// File: tb/sv/tftp_packet_parser_test.sv
module tftp_packet_parser_test;
    import tpp_pkg::*;

    typedef logic [7:0] t_octet_q[$];

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_BYTES  = 180;
    localparam int SHOWN_ERRORS = 10;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item = '0;
    logic      out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_item;

    tftp_packet_parser dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Predicted parse state for the datagram in flight.
    t_phase            parse_at;
    logic              second_half;
    logic [15:0]       opcode_acc;
    logic [15:0]       number_acc;
    logic [PLEN_W-1:0] payload_seen;
    logic [1:0]        fault_code;
    int                bytes_parsed;

    t_out_item expected_results[$];
    t_octet_q  datagram;

    int   send_idle_pct = 17;
    int   recv_idle_pct = 79;
    int   hold_left = 0;
    logic offering = 1'b0;
    int   cycle_count = 0;
    int   bytes_sent = 0;
    int   results_checked = 0;
    int   mismatches = 0;
    int   status_seen[4] = '{0, 0, 0, 0};

    function automatic void clear_parse_state();
        parse_at     = PH_OPCODE;
        second_half  = 1'b0;
        opcode_acc   = '0;
        number_acc   = '0;
        payload_seen = '0;
        fault_code   = STATUS_OK;
        bytes_parsed = 0;
    endfunction

    function automatic t_out_item classify_byte(input t_in_item req);
        t_out_item  res;
        logic [7:0] b;
        b = req.data_byte;
        res = '0;
        res.role = ROLE_IGNORED;
        res.byte_out = b;
        res.done_res = req.last_byte;
        // Bytes beyond the largest legal datagram are tagged ignored and change nothing.
        if (bytes_parsed < MAX_PACKET_BYTES) begin
            bytes_parsed++;
            case (parse_at)
                PH_OPCODE: begin
                    res.role = ROLE_OPCODE;
                    opcode_acc = {opcode_acc[7:0], b};
                    if (!second_half) begin
                        second_half = 1'b1;
                    end else begin
                        second_half = 1'b0;
                        if (opcode_acc == OPC_RRQ || opcode_acc == OPC_WRQ)
                            parse_at = PH_FILENAME;
                        else if (opcode_acc >= OPC_DATA &&
                                 opcode_acc <= OPC_ERROR)
                            parse_at = PH_NUMBER;
                        else begin
                            parse_at = PH_UNKNOWN;
                            fault_code = STATUS_UNKNOWN_OP;
                        end
                    end
                end
                PH_NUMBER: begin
                    res.role = ROLE_NUMBER;
                    number_acc = {number_acc[7:0], b};
                    if (!second_half) begin
                        second_half = 1'b1;
                    end else begin
                        second_half = 1'b0;
                        if (opcode_acc == OPC_DATA)
                            parse_at = PH_PAYLOAD;
                        else if (opcode_acc == OPC_ERROR)
                            parse_at = PH_MESSAGE;
                        else
                            parse_at = PH_TRAILER;
                    end
                end
                PH_FILENAME: begin
                    res.role = (b == 8'd0) ? ROLE_TERM : ROLE_FILENAME;
                    if (b == 8'd0) parse_at = PH_MODE;
                end
                PH_MODE: begin
                    res.role = (b == 8'd0) ? ROLE_TERM : ROLE_MODE;
                    if (b == 8'd0) parse_at = PH_TRAILER;
                end
                PH_MESSAGE: begin
                    res.role = (b == 8'd0) ? ROLE_TERM : ROLE_MESSAGE;
                    if (b == 8'd0) parse_at = PH_TRAILER;
                end
                PH_PAYLOAD: begin
                    res.role = ROLE_PAYLOAD;
                    if (payload_seen != '1) payload_seen++;
                end
                default: begin
                    res.role = ROLE_IGNORED;
                end
            endcase
        end
        if (req.last_byte) begin
            if (fault_code != STATUS_OK) begin
                res.status = fault_code;
                res.packet_opcode = opcode_acc;
            end else if (parse_at == PH_OPCODE || parse_at == PH_NUMBER) begin
                res.status = STATUS_TOO_SHORT;
            end else if (parse_at == PH_FILENAME || parse_at == PH_MODE ||
                         parse_at == PH_MESSAGE) begin
                res.status = STATUS_UNTERM;
                res.packet_opcode = opcode_acc;
                res.packet_number = number_acc;
            end else begin
                res.status = STATUS_OK;
                res.packet_opcode = opcode_acc;
                res.packet_number = number_acc;
                if (opcode_acc == OPC_DATA) res.payload_length = payload_seen;
            end
            status_seen[res.status]++;
            clear_parse_state();
        end
        return res;
    endfunction

    // Receiver: random stalls, or a long hold-off while hold_left runs down.
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left--;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n === 1'b1 && o_out_valid === 1'b1 && out_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("unexpected result: role %0d byte %h done %b status %0d",
                             o_out_item.role, o_out_item.byte_out, o_out_item.done_res,
                             o_out_item.status);
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (o_out_item.role !== want.role || o_out_item.byte_out !== want.byte_out ||
                    o_out_item.done_res !== want.done_res ||
                    o_out_item.status !== want.status ||
                    o_out_item.packet_opcode !== want.packet_opcode ||
                    o_out_item.packet_number !== want.packet_number ||
                    o_out_item.payload_length !== want.payload_length) begin
                    mismatches++;
                    if (mismatches <= SHOWN_ERRORS) begin
                        $display("result %0d mismatch (expected / actual):", results_checked);
                        $display("  role %0d/%0d byte %h/%h done %b/%b status %0d/%0d",
                                 want.role, o_out_item.role, want.byte_out,
                                 o_out_item.byte_out, want.done_res, o_out_item.done_res,
                                 want.status, o_out_item.status);
                        $display("  opcode %h/%h number %h/%h length %0d/%0d",
                                 want.packet_opcode, o_out_item.packet_opcode,
                                 want.packet_number, o_out_item.packet_number,
                                 want.payload_length, o_out_item.payload_length);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timed out after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("tftp_packet_parser regression: fail");
            $finish;
        end
    end

    // The sender tasks are entered and left at a falling edge.
    task automatic stop_offer();
        if (offering) begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            stop_offer();
            @(negedge clk);
        end
        in_item  <= '{data_byte: b, last_byte: last};
        in_valid <= 1'b1;
        offering = 1'b1;
        do @(posedge clk); while (o_in_ready !== 1'b1);
        expected_results.push_back(classify_byte(in_item));
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_datagram();
        for (int k = 0; k < datagram.size(); k++)
            send_byte(datagram[k], k == datagram.size() - 1);
    endtask

    task automatic wait_drained();
        stop_offer();
        while (expected_results.size() != 0) @(negedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        stop_offer();
        @(posedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        @(negedge clk);
    endtask

    task automatic hold_receiver(input int cycles);
        stop_offer();
        @(posedge clk);
        hold_left = cycles;
        @(negedge clk);
    endtask

    function automatic void add_string();
        int len;
        len = $urandom_range(0, 6);
        repeat (len) datagram.push_back(8'($urandom_range(1, 255)));
        datagram.push_back(8'h00);
    endfunction

    // Mostly well-formed datagrams with random content; some are cut short, carry a
    // trailer or use an opcode outside the protocol.
    function automatic void build_random_datagram();
        logic [15:0] opcode;
        int          n;
        datagram = {};
        if ($urandom_range(99) < 8) begin
            do opcode = 16'($urandom); while (opcode >= OPC_RRQ &&
                                              opcode <= OPC_ERROR);
        end else begin
            opcode = 16'($urandom_range(OPC_RRQ, OPC_ERROR));
        end
        datagram.push_back(opcode[15:8]);
        datagram.push_back(opcode[7:0]);
        case (opcode)
            OPC_RRQ, OPC_WRQ: begin
                add_string();
                add_string();
            end
            OPC_DATA: begin
                datagram.push_back(8'($urandom));
                datagram.push_back(8'($urandom));
                n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 24);
                repeat (n) datagram.push_back(8'($urandom));
            end
            OPC_ACK: begin
                datagram.push_back(8'($urandom));
                datagram.push_back(8'($urandom));
            end
            OPC_ERROR: begin
                datagram.push_back(8'($urandom));
                datagram.push_back(8'($urandom));
                add_string();
            end
            default: begin
                repeat ($urandom_range(0, 4)) datagram.push_back(8'($urandom));
            end
        endcase
        if ($urandom_range(99) < 12)
            repeat ($urandom_range(1, 4)) datagram.push_back(8'($urandom));
        if ($urandom_range(99) < 15) begin
            n = $urandom_range(1, datagram.size());
            while (datagram.size() > n) void'(datagram.pop_back());
        end
    endfunction

    task automatic test_every_opcode();
        datagram = '{8'h00, 8'h01, 8'h66, 8'h00, 8'h00};
        send_datagram();
        // Write request followed by a trailer byte.
        datagram = '{8'h00, 8'h02, 8'h00, 8'h00, 8'h99};
        send_datagram();
        datagram = '{8'h00, 8'h03, 8'hFF, 8'hFF, 8'h80};
        send_datagram();
        datagram = '{8'h00, 8'h04, 8'hFF, 8'hFF};
        send_datagram();
        datagram = '{8'h00, 8'h05, 8'h00, 8'h00, 8'h00};
        send_datagram();
        wait_drained();
    endtask

    task automatic test_malformed();
        datagram = '{8'hFF};
        send_datagram();
        datagram = '{8'h00, 8'h03, 8'h12};
        send_datagram();
        datagram = '{8'h00, 8'h01, 8'h41};
        send_datagram();
        datagram = '{8'hFF, 8'hFF, 8'h7F};
        send_datagram();
        wait_drained();
    endtask

    task automatic test_oversize();
        datagram = '{8'h00, 8'h03, 8'h00, 8'h01};
        repeat (MAX_PACKET_BYTES + 4) datagram.push_back(8'($urandom));
        send_datagram();
        wait_drained();
    endtask

    // The receiver stops for a long stretch while requests keep coming, so the
    // parser has to stall its input.
    task automatic test_backpressure();
        int start;
        set_idling(0, 0);
        hold_receiver(60);
        start = bytes_sent;
        while (bytes_sent - start < 80) begin
            build_random_datagram();
            send_datagram();
        end
        wait_drained();
    endtask

    task automatic test_random(input int send_pct, input int recv_pct);
        int start;
        set_idling(send_pct, recv_pct);
        start = bytes_sent;
        while (bytes_sent - start < PHASE_BYTES) begin
            build_random_datagram();
            send_datagram();
        end
        wait_drained();
    endtask

    initial begin
        clear_parse_state();
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_every_opcode();
        test_malformed();
        test_oversize();
        test_backpressure();
        test_random(17, 79);
        test_random(79, 17);
        test_random(0, 0);
        wait_drained();
        repeat (5) @(posedge clk);
        $display("%0d bytes classified, %0d results checked, %0d mismatches",
                 bytes_sent, results_checked, mismatches);
        $display("datagrams: %0d ok, %0d too short, %0d unterminated, %0d unknown opcode",
                 status_seen[STATUS_OK], status_seen[STATUS_TOO_SHORT],
                 status_seen[STATUS_UNTERM], status_seen[STATUS_UNKNOWN_OP]);
        if (mismatches == 0)
            $display("tftp_packet_parser regression: pass");
        else
            $display("tftp_packet_parser regression: fail");
        $finish;
    end

endmodule

// File: tftp_packet_parser.f
+incdir+hw/rtl
hw/rtl/tpp_pkg.sv
hw/rtl/tftp_packet_parser.sv
hw/rtl/tpp_checker.sv
tb/sv/tftp_packet_parser_test.sv
